>>> hdl/mbphd_pkg.sv
// Shared constants and types for the multi-button press and hold detector.
package mbphd_pkg;

    localparam int BUTTONS          = 7;
    localparam int TIME_WIDTH       = 16;
    localparam int DT_WIDTH         = 10;
    localparam int CFG_DATA_WIDTH   = 16;
    localparam int CFG_INDEX_WIDTH  = 2;

    localparam logic [BUTTONS-1:0]    ENABLE_MASK_RESET = 7'd127;
    localparam logic [BUTTONS-1:0]    IDLE_LEVELS_RESET = 7'd127;
    localparam logic [TIME_WIDTH-1:0] PRESS_THR_RESET   = 16'd100;
    localparam logic [TIME_WIDTH-1:0] LONG_THR_RESET    = 16'd2000;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_ENABLE_MASK = 2'd0,
        REG_IDLE_LEVELS = 2'd1,
        REG_PRESS_THR   = 2'd2,
        REG_LONG_THR    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic press;
        logic hold;
        logic release_ev;
        logic long_release;
    } lane_events_t;

endpackage

>>> hdl/mbphd_lane.sv
// One button lane: pressed flag, pressed-time accumulator and event decode.
module mbphd_lane
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           enable,
    input  logic                           idle_level,
    input  logic                           pin,
    input  logic [mbphd_pkg::DT_WIDTH-1:0]   dt,
    input  logic [mbphd_pkg::TIME_WIDTH-1:0] press_thr,
    input  logic [mbphd_pkg::TIME_WIDTH-1:0] long_thr,
    output mbphd_pkg::lane_events_t        events
);
    import mbphd_pkg::*;

    logic                  pressed_reg;
    logic                  pressed_next;
    logic [TIME_WIDTH-1:0] time_reg;
    logic [TIME_WIDTH-1:0] time_next;
    logic [TIME_WIDTH:0]   time_sum;
    logic                  is_pressed;

    assign is_pressed = (pin != idle_level);
    assign time_sum   = {1'b0, time_reg} + {{(TIME_WIDTH + 1 - DT_WIDTH){1'b0}}, dt};

    always_comb
    begin
        events       = '0;
        pressed_next = pressed_reg;
        time_next    = time_reg;
        if (enable)
        begin
            if (!is_pressed)
            begin
                events.long_release = pressed_reg && (time_reg > long_thr);
                events.release_ev   = pressed_reg && (time_reg > press_thr);
                pressed_next        = 1'b0;
                time_next           = '0;
            end
            else
            begin
                events.press = !pressed_reg;
                events.hold  = (time_reg > press_thr);
                pressed_next = 1'b1;
                // Pressed time sticks at its maximum.
                time_next    = time_sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}}
                                                    : time_sum[TIME_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= 1'b0;
            time_reg    <= '0;
        end
        else if (advance)
        begin
            pressed_reg <= pressed_next;
            time_reg    <= time_next;
        end
    end

endmodule

>>> hdl/multi_button_press_hold_detector.sv
// Top level of the multi-button press, hold and release detector.
//
//  Channel   Direction  Handshake           Payload
//  in        input      in_valid/in_ready   pin_levels, elapsed_ms
//  out       output     out_valid/out_ready press/hold/release/long_release_events
//  cfg       input      cfg_we              cfg_index, cfg_data
//
// Each tick beat is taken into an input register and then moves to a result register,
// so one beat is taken every cycle when the output drains.
// The per-button state updates in the cycle the beat moves to the result register.
// Reset clears all button state and loads the default register values.
// A stalled output holds its beat; the input register still takes one more beat.
module multi_button_press_hold_detector
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [mbphd_pkg::BUTTONS-1:0]         pin_levels,
    input  logic [mbphd_pkg::DT_WIDTH-1:0]        elapsed_ms,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [mbphd_pkg::BUTTONS-1:0]         press_events,
    output logic [mbphd_pkg::BUTTONS-1:0]         hold_events,
    output logic [mbphd_pkg::BUTTONS-1:0]         release_events,
    output logic [mbphd_pkg::BUTTONS-1:0]         long_release_events,
    input  logic                                  cfg_we,
    input  logic [mbphd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [mbphd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import mbphd_pkg::*;

    logic [BUTTONS-1:0]    enable_mask_reg;
    logic [BUTTONS-1:0]    idle_levels_reg;
    logic [TIME_WIDTH-1:0] press_thr_reg;
    logic [TIME_WIDTH-1:0] long_thr_reg;

    logic                  in_valid_reg;
    logic [BUTTONS-1:0]    pins_reg;
    logic [DT_WIDTH-1:0]   dt_reg;

    logic                  out_valid_reg;
    logic [BUTTONS-1:0]    press_reg;
    logic [BUTTONS-1:0]    hold_reg;
    logic [BUTTONS-1:0]    release_reg;
    logic [BUTTONS-1:0]    long_reg;

    logic                  advance;
    lane_events_t          lane_events [BUTTONS];

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_mask_reg <= ENABLE_MASK_RESET;
            idle_levels_reg <= IDLE_LEVELS_RESET;
            press_thr_reg   <= PRESS_THR_RESET;
            long_thr_reg    <= LONG_THR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ENABLE_MASK: enable_mask_reg <= cfg_data[BUTTONS-1:0];
                REG_IDLE_LEVELS: idle_levels_reg <= cfg_data[BUTTONS-1:0];
                REG_PRESS_THR:   press_thr_reg   <= cfg_data[TIME_WIDTH-1:0];
                REG_LONG_THR:    long_thr_reg    <= cfg_data[TIME_WIDTH-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pins_reg <= pin_levels;
            dt_reg   <= elapsed_ms;
        end
    end

    genvar i;
    generate
        for (i = 0; i < BUTTONS; i++)
        begin : g_lane
            mbphd_lane u_lane
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .advance    (advance),
                .enable     (enable_mask_reg[i]),
                .idle_level (idle_levels_reg[i]),
                .pin        (pins_reg[i]),
                .dt         (dt_reg),
                .press_thr  (press_thr_reg),
                .long_thr   (long_thr_reg),
                .events     (lane_events[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int b = 0; b < BUTTONS; b++)
            begin
                press_reg[b]   <= lane_events[b].press;
                hold_reg[b]    <= lane_events[b].hold;
                release_reg[b] <= lane_events[b].release_ev;
                long_reg[b]    <= lane_events[b].long_release;
            end
        end
    end

    assign out_valid           = out_valid_reg;
    assign press_events        = press_reg;
    assign hold_events         = hold_reg;
    assign release_events      = release_reg;
    assign long_release_events = long_reg;

endmodule

>>> hdl/mbphd_checker.sv
// Port-level checker for the button detector, bound to the top level.
module mbphd_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [mbphd_pkg::BUTTONS-1:0] press_events,
    input logic [mbphd_pkg::BUTTONS-1:0] hold_events,
    input logic [mbphd_pkg::BUTTONS-1:0] release_events,
    input logic [mbphd_pkg::BUTTONS-1:0] long_release_events
);
    import mbphd_pkg::*;

    // A stalled result beat stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(press_events)
            && $stable(hold_events) && $stable(release_events)
            && $stable(long_release_events))
        else $error("result beat changed while stalled");

    // A button is either pressed or released on one tick, never both.
    a_press_vs_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (((press_events | hold_events)
            & (release_events | long_release_events)) == '0))
        else $error("pressed and released events on the same button");

    // A new press starts from zero time, so it cannot be a hold as well.
    a_press_not_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((press_events & hold_events) == '0))
        else $error("press and hold events on the same button");

endmodule

bind multi_button_press_hold_detector mbphd_checker u_mbphd_checker
(
    .clk                 (clk),
    .rst_n               (rst_n),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .press_events        (press_events),
    .hold_events         (hold_events),
    .release_events      (release_events),
    .long_release_events (long_release_events)
);
